/* rtl/tmts_pkg.sv */
// Shared widths, constants, register indices and sequencer states of the trimmed-mean sensor.
`default_nettype none

package tmts_pkg;

    localparam int READING_W  = 12;
    localparam int SAMPLE_W   = 13;
    localparam int OFFSET_W   = 10;
    localparam int SLOPE_W    = 8;
    localparam int TEMP_W     = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int NUM_SAMPLES_DEF = 16;
    localparam int KEEP_COUNT_DEF  = 8;

    localparam logic [SLOPE_W-1:0] SLOPE_RESET = 8'h1c;
    localparam int BASE_TEMP   = 25;
    localparam int SLOPE_SHIFT = 9;

    // corrected reading and product widths
    localparam int NTS_W  = SAMPLE_W + 1;
    localparam int PROD_W = NTS_W + SLOPE_W + 1;
    localparam int SHR_W  = PROD_W - SLOPE_SHIFT;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/tmts_sample_mem.sv */
// Sample store: one write port, one registered read port.
`default_nettype none

module tmts_sample_mem
    import tmts_pkg::*;
#(
    parameter int DEPTH = NUM_SAMPLES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic signed [SAMPLE_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr,
    output logic signed [SAMPLE_W-1:0]      o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/tmts_divider.sv */
// Division by a constant through a reciprocal multiply of the magnitude, truncating toward zero.
`default_nettype none

module tmts_divider
    import tmts_pkg::*;
#(
    parameter int DIVISOR = KEEP_COUNT_DEF,
    parameter int DW      = 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_dividend,
    output logic                      o_done,
    output logic signed [SAMPLE_W-1:0] o_quotient
);

    // magnitude bits, reciprocal scale and width
    localparam int     MW      = DW - 1;
    localparam int     LOG_D   = $clog2(DIVISOR);
    localparam int     SH      = MW + LOG_D;
    localparam int     RW      = MW + 2;
    localparam int     PW      = MW + RW;
    localparam longint RECIP   = ((longint'(1) << SH) + longint'(DIVISOR) - 1) /
                                 longint'(DIVISOR);
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [MW-1:0] r_mag;
    logic [MW-1:0] r_quo;

    logic [DW-1:0] mag;
    logic [PW-1:0] prod;
    logic [MW-1:0] signed_q;

    assign mag  = i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
    assign prod = PW'(r_mag) * PW'(RECIP_C);

    // Latch the magnitude on start, multiply the next cycle, flag done after that.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_mag <= mag[MW-1:0];
        end
        if (r_busy) begin
            r_quo <= MW'(prod[PW-1:SH]);
        end
    end

    assign signed_q   = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_done     = r_done;
    assign o_quotient = signed_q[SAMPLE_W-1:0];

endmodule

`default_nettype wire

/* rtl/trimmed_mean_temperature_sensor_top.sv */
// Top level of the trimmed-mean temperature sensor: sequencer, calibration and handshakes.
// Each word is inserted into the descending store by moving every stored sample smaller than it
// down one place, one read and one compare per sample; one read port and one compare set this pace.
// The word completing a set then goes through sum, divide, multiply and output load, and the
// result waits for the output slot while the output stalls.
// Throughput: one word at a time. Sync reset empties set and output slot, restores calibration.
`default_nettype none

module trimmed_mean_temperature_sensor_top
    import tmts_pkg::*;
#(
    parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
    parameter int KEEP_COUNT  = KEEP_COUNT_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input words
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [READING_W-1:0]    i_reading_switch_off,
    input  wire logic [READING_W-1:0]    i_reading_switch_on,
    // result words
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [TEMP_W-1:0]     o_temperature_c,
    // calibration registers
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IW    = $clog2(NUM_SAMPLES);
    localparam int SUM_W = SAMPLE_W + IW + 1;
    // Window of the sorted (descending) store that is summed; all of it when the
    // window would be wider than the store.
    localparam int FIRST = (KEEP_COUNT >= NUM_SAMPLES) ? 0 : (NUM_SAMPLES - KEEP_COUNT) / 2;
    localparam int LAST  = (KEEP_COUNT >= NUM_SAMPLES) ? NUM_SAMPLES : FIRST + KEEP_COUNT;
    localparam logic [IW-1:0] FIRST_IDX = IW'(FIRST);
    localparam logic [IW-1:0] LAST_IDX  = IW'(LAST - 1);
    localparam logic [IW-1:0] FULL_IDX  = IW'(NUM_SAMPLES - 1);

    t_state r_state;
    t_state n_state;

    // calibration
    logic signed [OFFSET_W-1:0] r_offset;
    logic        [SLOPE_W-1:0]  r_slope;

    // collection and insertion
    logic [IW-1:0]              r_count;
    logic [IW-1:0]              r_pos;
    logic signed [SAMPLE_W-1:0] r_val;

    // summing, division and scaling
    logic [IW-1:0]              r_idx;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic signed [PROD_W-1:0]   r_prod;

    // output slot
    logic                       r_out_valid;
    logic signed [TEMP_W-1:0]   r_temp;

    // sample store port
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [IW-1:0]              mem_raddr;
    logic signed [SAMPLE_W-1:0] mem_rdata;

    logic                       div_start;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_q;

    logic                       in_accept;
    logic                       shift_down;
    logic                       ins_done;
    logic                       set_full;
    logic                       emit_load;
    logic signed [SAMPLE_W-1:0] diff;
    logic signed [NTS_W-1:0]    nts;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [SHR_W-1:0]    temp_full;

    assign in_accept  = i_in_valid && o_in_ready;
    assign diff       = $signed({1'b0, i_reading_switch_on}) -
                        $signed({1'b0, i_reading_switch_off});
    // Displace the stored entry when it sorts below the new sample.
    assign shift_down = (mem_rdata < r_val);
    assign set_full   = (r_count == FULL_IDX);
    assign emit_load  = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    // Negated corrected reading, then scale by the slope.
    assign nts      = $signed({{(NTS_W-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset}) -
                      $signed({r_mean[SAMPLE_W-1], r_mean});
    assign mul_prod = $signed({{(PROD_W-NTS_W){nts[NTS_W-1]}}, nts}) *
                      $signed({{(PROD_W-SLOPE_W){1'b0}}, r_slope});
    // Arithmetic shift by the slope exponent is a floor; add the base temperature.
    assign temp_full = r_prod[PROD_W-1:SLOPE_SHIFT] + SHR_W'(BASE_TEMP);

    tmts_sample_mem #(
        .DEPTH (NUM_SAMPLES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tmts_divider #(
        .DIVISOR (KEEP_COUNT),
        .DW      (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (r_pos == '0) begin
                    n_state = set_full ? ST_SUM_RD : ST_IDLE;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (shift_down) begin
                    n_state = ST_RD;
                end else begin
                    n_state = set_full ? ST_SUM_RD : ST_IDLE;
                end
            end
            ST_SUM_RD: begin
                n_state = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                n_state = (r_idx == LAST_IDX) ? ST_DIV_GO : ST_SUM_RD;
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs to the store, divider and handshake.
    always_comb begin
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = r_val;
        mem_re     = 1'b0;
        mem_raddr  = r_idx;
        div_start  = 1'b0;
        ins_done   = 1'b0;
        unique case (r_state) inside
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_RD: begin
                if (r_pos == '0) begin
                    // top of the store reached: place the sample here
                    mem_we   = 1'b1;
                    ins_done = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_pos - 1'b1;
                end
            end
            ST_CMP: begin
                mem_we = 1'b1;
                if (shift_down) begin
                    mem_wdata = mem_rdata;
                end else begin
                    ins_done = 1'b1;
                end
            end
            ST_SUM_RD: begin
                mem_re = 1'b1;
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
            end
            ST_SUM_ACC, ST_DIV_WAIT, ST_MUL, ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Calibration registers: written at any time, used at the end of a set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_slope  <= SLOPE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET: r_offset <= $signed(i_cfg_data[OFFSET_W-1:0]);
                CFG_SLOPE:  r_slope  <= i_cfg_data[SLOPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Collection count and output slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ins_done) begin
                r_count <= set_full ? '0 : r_count + 1'b1;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_val <= diff;
            r_pos <= r_count;
        end
        if ((r_state == ST_CMP) && shift_down) begin
            r_pos <= r_pos - 1'b1;
        end
        if (ins_done) begin
            r_idx <= FIRST_IDX;
            r_sum <= '0;
        end
        if (r_state == ST_SUM_ACC) begin
            r_sum <= r_sum + $signed({{(SUM_W-SAMPLE_W){mem_rdata[SAMPLE_W-1]}}, mem_rdata});
            r_idx <= r_idx + 1'b1;
        end
        if (div_done) begin
            r_mean <= div_q;
        end
        if (r_state == ST_MUL) begin
            r_prod <= mul_prod;
        end
        if (emit_load) begin
            r_temp <= temp_full[TEMP_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_temperature_c = r_temp;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench of the trimmed-mean temperature sensor top level.
`timescale 1ns / 1ps

module tb_top;
    import tmts_pkg::*;

    localparam int HELD           = NUM_SAMPLES_DEF;
    localparam int KEEP           = KEEP_COUNT_DEF;
    localparam int TRIM           = (HELD - KEEP) / 2;
    localparam int ITEM_TARGET    = 1450;
    // worst idle item (a word moved past every held sample), plus a margin
    localparam int SETTLE_CYCLES  = 48;
    localparam int LONG_HOLD      = 1200;
    localparam int WATCHDOG_LIMIT = 8000;

    typedef struct packed {
        logic [READING_W-1:0] off;
        logic [READING_W-1:0] on;
    } t_reading_pair;

    // DUT connections, all inputs known from time zero
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [READING_W-1:0]         i_reading_switch_off = '0;
    logic [READING_W-1:0]         i_reading_switch_on = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [TEMP_W-1:0]     o_temperature_c;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    // words waiting for the driver, and temperatures waiting for the monitor
    t_reading_pair                pending_pairs[$];
    logic signed [TEMP_W-1:0]     expected_temps[$];

    // predictor state: collected differences and calibration copy
    logic signed [SAMPLE_W-1:0]   held_diff[HELD];
    int                           n_held = 0;
    logic signed [OFFSET_W-1:0]   cal_offset = '0;
    logic [SLOPE_W-1:0]           cal_slope = SLOPE_RESET;

    int                           n_pushed = 0;
    int                           n_taken = 0;
    int                           n_temps_seen = 0;
    int                           n_errors = 0;
    int                           src_gap = 0;
    int                           sink_wait = 0;
    int                           quiet_cycles = 0;
    bit                           src_steady = 1'b0;
    bit                           sink_steady = 1'b0;
    bit                           long_hold_done = 1'b0;
    t_reading_pair                next_pair;

    // per-set shaping of the random words
    int                           set_style = 0;
    int                           set_centre = 0;
    int                           ext_kind = 0;
    int                           dup_diff[3];

    trimmed_mean_temperature_sensor_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_reading_switch_off (i_reading_switch_off),
        .i_reading_switch_on  (i_reading_switch_on),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_temperature_c      (o_temperature_c),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            idle_len = 0;
        end else if (r < 85) begin
            idle_len = $urandom_range(1, 3);
        end else if (r < 97) begin
            idle_len = $urandom_range(4, 12);
        end else begin
            idle_len = $urandom_range(20, 60);
        end
    endfunction

    // Trimmed mean of the held set, calibrated into degrees Celsius.
    function automatic logic signed [TEMP_W-1:0] trimmed_temperature();
        int ordered[HELD];
        int v;
        int j;
        int sum;
        int mean;
        int corrected;
        int scaled;
        int degrees;
        for (int i = 0; i < HELD; i++) ordered[i] = int'(held_diff[i]);
        // insertion sort, ascending; the trim is symmetric so direction is irrelevant
        for (int i = 1; i < HELD; i++) begin
            v = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > v) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        sum = 0;
        for (int i = TRIM; i < TRIM + KEEP; i++) sum += ordered[i];
        mean      = sum / KEEP;                        // truncates toward zero
        corrected = mean - int'(cal_offset);
        scaled    = -corrected * int'(cal_slope);
        degrees   = (scaled >>> SLOPE_SHIFT) + BASE_TEMP;  // floor shift
        trimmed_temperature = degrees[TEMP_W-1:0];
    endfunction

    // Fold one accepted word into the collection; a full set yields a temperature.
    task automatic fold_in_reading(input t_reading_pair p);
        held_diff[n_held] = SAMPLE_W'(int'(p.on) - int'(p.off));
        n_held++;
        if (n_held == HELD) begin
            n_held = 0;
            expected_temps.push_back(trimmed_temperature());
        end
    endtask

    task automatic check_temperature(input logic signed [TEMP_W-1:0] got);
        logic signed [TEMP_W-1:0] want;
        n_temps_seen++;
        if (expected_temps.size() == 0) begin
            $display("%0t: temperature %0d arrived with none expected", $time, got);
            n_errors++;
        end else begin
            want = expected_temps.pop_front();
            if (got !== want) begin
                $display("%0t: temperature mismatch, expected %0d, actual %0d",
                         $time, want, got);
                n_errors++;
            end
        end
    endtask

    // Driver: hold each word until accepted, then idle a random gap before the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap    <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                fold_in_reading({i_reading_switch_off, i_reading_switch_on});
                n_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (src_gap != 0) begin
                    src_gap    <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    next_pair            = pending_pairs.pop_front();
                    i_in_valid           <= 1'b1;
                    i_reading_switch_off <= next_pair.off;
                    i_reading_switch_on  <= next_pair.on;
                    src_gap              <= src_steady ? 0 : idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every accepted temperature and stall the output at random.
    // After the fourth result, hold off for a long stretch so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_wait   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) check_temperature(o_temperature_c);
            if (sink_wait != 0) begin
                sink_wait   <= sink_wait - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!long_hold_done && n_temps_seen == 4) begin
                    long_hold_done = 1'b1;
                    sink_wait <= LONG_HOLD;
                end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                    sink_wait <= idle_len();
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
        begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_pair(input int off, input int on);
        pending_pairs.push_back({READING_W'(off), READING_W'(on)});
        n_pushed++;
    endtask

    // Push a word pair whose difference (on minus off) is d, placed at random.
    task automatic push_diff(input int d);
        int base;
        if (d > 4095) d = 4095;
        if (d < -4095) d = -4095;
        if (d >= 0) begin
            base = $urandom_range(0, 4095 - d);
            push_pair(base, base + d);
        end else begin
            base = $urandom_range(0, 4095 + d);
            push_pair(base - d, base);
        end
    endtask

    // Random words, shaped per collection: uniform, clustered, corner values or repeats.
    task automatic push_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (n_pushed % HELD == 0) begin
                set_style  = $urandom_range(0, 3);
                set_centre = int'($urandom_range(0, 8190)) - 4095;
                ext_kind   = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++) dup_diff[i] = int'($urandom_range(0, 8190)) - 4095;
            end
            case (set_style)
                0: push_pair($urandom_range(0, 4095), $urandom_range(0, 4095));
                1: push_diff(set_centre + int'($urandom_range(0, 40)) - 20);
                2: begin
                    if (ext_kind == 0) push_pair(0, 4095);
                    else if (ext_kind == 1) push_pair(4095, 0);
                    else push_pair($urandom_range(0, 1) * 4095, $urandom_range(0, 1) * 4095);
                end
                default: push_diff(dup_diff[$urandom_range(0, 2)]);
            endcase
        end
    endtask

    // Wait until every word is taken and every temperature checked, then let the
    // sequencer finish any word that yields no result.
    task automatic drain_and_settle();
        do @(posedge i_clk); while (n_taken != n_pushed || expected_temps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OFFSET) cal_offset = data[OFFSET_W-1:0];
        else cal_slope = data[SLOPE_W-1:0];
    endtask

    // Unused upper bits of the slope write carry random values.
    task automatic set_calibration(input int offset, input int slope);
        write_reg(CFG_OFFSET, CFG_DATA_W'(offset));
        write_reg(CFG_SLOPE, CFG_DATA_W'(slope) |
                             (CFG_DATA_W'($urandom_range(0, 3)) << SLOPE_W));
    endtask

    initial begin : stimulus
        int phase;
        int plen;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First set at reset calibration: full-scale differences, ties, alternating bits.
        push_pair(0, 4095);
        push_pair(4095, 0);
        push_pair(0, 0);
        push_pair(4095, 4095);
        push_pair(2048, 2047);
        push_pair(2047, 2048);
        push_pair(1, 0);
        push_pair(0, 1);
        push_pair(12'hAAA, 12'h555);
        push_pair(12'h555, 12'hAAA);
        push_pair(100, 100);
        push_pair(100, 100);
        push_pair(4095, 0);
        push_pair(4095, 0);
        push_pair(0, 4095);
        push_pair(0, 4095);
        // Start the next set, then recalibrate with half of it collected.
        push_pair(0, 4095);
        push_pair(0, 4095);
        push_pair(0, 4095);
        push_pair(0, 4095);
        push_pair(0, 4095);
        push_pair(0, 4095);
        push_pair(0, 4095);
        push_pair(0, 4095);
        drain_and_settle();
        set_calibration(-512, 255);
        // Finish that set at full scale so the extreme output is reached.
        set_style = 2;
        ext_kind  = 0;

        phase = 0;
        while (n_pushed < ITEM_TARGET) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            plen = (phase == 0) ? $urandom_range(120, 200) : $urandom_range(40, 200);
            if (plen > ITEM_TARGET - n_pushed) plen = ITEM_TARGET - n_pushed;
            push_random(plen);
            drain_and_settle();
            case (phase)
                0: set_calibration(511, 255);
                1: set_calibration(511, 0);
                2: set_calibration(-512, 0);
                3: set_calibration(0, SLOPE_RESET);
                default: set_calibration(int'($urandom_range(0, 1023)) - 512,
                                         $urandom_range(0, 255));
            endcase
            phase++;
        end

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tmts_pkg.sv
rtl/tmts_sample_mem.sv
rtl/tmts_divider.sv
rtl/trimmed_mean_temperature_sensor_top.sv
dv/tb_top.sv
